### src/mtne_pkg.sv
// Shared types and constants of the MIDI track note extractor.
`timescale 1ns / 1ps
`default_nettype none
package mtne_pkg;

  localparam int PEND_DEPTH = 16;
  localparam int CNT_W      = $clog2(PEND_DEPTH + 1);
  localparam int TEMPO_W    = 24;
  localparam int TIME_W     = 64;
  localparam logic [TEMPO_W-1:0] TEMPO_RST = 24'd500000;

  localparam logic [7:0] DATA_MASK   = 8'h7F;
  localparam logic [7:0] ST_SYS      = 8'hF0;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_ESCAPE   = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [3:0] KIND_OFF    = 4'h8;
  localparam logic [3:0] KIND_ON     = 4'h9;
  localparam logic [3:0] KIND_PROG   = 4'hC;
  localparam logic [3:0] KIND_PRESS  = 4'hD;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE,
    PH_META_LEN, PH_META_DATA, PH_SYSEX_LEN, PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {S_IDLE, S_ADD, S_EMIT, S_FLUSH} fsm_t;

  typedef struct packed {
    logic [7:0]        note;
    logic [3:0]        chan;
    logic [TIME_W-1:0] start;
    logic [7:0]        vel;
  } pend_t;

  typedef struct packed {
    logic ins;    // write new entry at the fill position
    logic shift;  // every cell takes its neighbor (flush)
    logic rm;     // cells at and after the hit take their neighbor
  } cell_ctl_t;

endpackage
`default_nettype wire

### src/mtne_if.sv
// Valid/ready channel interfaces for bytes in and notes out.
`timescale 1ns / 1ps
`default_nettype none
interface mtne_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_track;
  logic       first_of_file;
  logic       last_of_track;
  modport source(output valid, data_byte, first_of_track, first_of_file, last_of_track,
                 input ready);
  modport sink(input valid, data_byte, first_of_track, first_of_file, last_of_track,
               output ready);
endinterface

interface mtne_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] note_start;
  logic [63:0] note_length;
  logic [7:0]  pitch;
  logic [7:0]  velocity;
  logic        last_result;
  modport source(output valid, note_start, note_length, pitch, velocity, last_result,
                 input ready);
  modport sink(input valid, note_start, note_length, pitch, velocity, last_result,
               output ready);
endinterface
`default_nettype wire

### src/midi_track_note_extractor_core.sv
// Top level: track byte parser, tempo timebase and note output register.
//
//  channel  | dir | handshake      | payload
//  in_if    | in  | valid/ready    | data_byte, first_of_track, first_of_file, last_of_track
//  out_if   | out | valid/ready    | note_start, note_length, pitch, velocity, last_result
//  cfg_*    | in  | cfg_wr_en      | cfg_wr_data = default tempo (us per quarter note)
//
// A byte that completes a delta time also passes through S_ADD: the delta times
// tempo product is registered, then added to the time with saturation. A closing
// note-off passes through S_EMIT to hand its note to the output register, and the
// final byte of a track passes through S_FLUSH, which emits every pending note.
// A stalled output holds emitting states; input is not taken outside S_IDLE.
// Reset (rst_n, synchronous) clears parser state, time and fill count; cells are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module midi_track_note_extractor_core (
  input  wire                             clk,
  input  wire                             rst_n,
  mtne_in_if.sink                         in_if,
  mtne_out_if.source                      out_if,
  input  wire                             cfg_wr_en,
  input  wire [mtne_pkg::TEMPO_W-1:0]     cfg_wr_data
);
  import mtne_pkg::*;

  // Control and parser state
  fsm_t                 state_r, state_nxt;
  phase_t               ph_r, ph_nxt;
  logic [31:0]          vl_r, vl_nxt;
  logic [7:0]           rs_r, rs_nxt;
  logic [7:0]           cs_r, cs_nxt;
  logic [7:0]           fd_r, fd_nxt;
  logic [7:0]           mk_r, mk_nxt;
  logic [31:0]          bl_r, bl_nxt;
  logic [TEMPO_W-1:0]   tg_r, tg_nxt;
  logic [TEMPO_W-1:0]   tempo_r, tempo_nxt;
  logic [TEMPO_W-1:0]   dflt_r;
  logic [TIME_W-1:0]    time_r, time_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 last_r, last_nxt;

  // Datapath registers
  logic [55:0]          prod_r, prod_nxt;
  pend_t                emit_r, emit_nxt;

  // Output register
  logic                 ov_r, ov_nxt;
  logic [TIME_W-1:0]    o_start_r, o_start_nxt;
  logic [TIME_W-1:0]    o_len_r, o_len_nxt;
  logic [7:0]           o_pitch_r, o_pitch_nxt;
  logic [7:0]           o_vel_r, o_vel_nxt;
  logic                 o_last_r, o_last_nxt;

  // Chain hookup
  cell_ctl_t            ctl;
  logic [CNT_W-1:0]     ch_cnt;
  pend_t                key, new_ent, hit_ent, head;
  logic                 found;

  logic                 accept;
  logic                 out_free;
  logic [64:0]          sum;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign out_free    = !ov_r || out_if.ready;
  assign sum         = {1'b0, time_r} + {9'd0, prod_r};

  assign out_if.valid       = ov_r;
  assign out_if.note_start  = o_start_r;
  assign out_if.note_length = o_len_r;
  assign out_if.pitch       = o_pitch_r;
  assign out_if.velocity    = o_vel_r;
  assign out_if.last_result = o_last_r;

  mtne_chain u_chain (
    .clk    (clk),
    .ctl    (ctl),
    .cnt    (ch_cnt),
    .key    (key),
    .new_ent(new_ent),
    .found  (found),
    .hit_ent(hit_ent),
    .head   (head)
  );

  always_comb begin
    logic [7:0]         b;
    logic               lst;
    phase_t             ph;
    logic [31:0]        vl, vl_sh, bl_dec;
    logic [7:0]         rs, cs, fd, mk;
    logic [31:0]        bl;
    logic [TEMPO_W-1:0] tg, tmp;
    logic [TIME_W-1:0]  tm;
    logic               dn;
    logic [CNT_W-1:0]   cnt;
    logic               do_mul, do_note, note_on, data1;
    logic [7:0]         note_b, vel_b;
    logic [3:0]         kind;
    pend_t              src;
    logic               ld_out, ld_last;

    b   = in_if.data_byte;
    lst = in_if.last_of_track;

    // Apply track / file starts ahead of the byte
    if (in_if.first_of_track) begin
      ph = PH_DELTA; vl = '0; rs = '0; cs = '0; fd = '0; mk = '0; bl = '0; tg = '0;
      tm = '0; dn = 1'b0; cnt = '0;
    end else begin
      ph = ph_r; vl = vl_r; rs = rs_r; cs = cs_r; fd = fd_r; mk = mk_r; bl = bl_r;
      tg = tg_r; tm = time_r; dn = done_r; cnt = cnt_r;
    end
    tmp = in_if.first_of_file ? dflt_r : tempo_r;

    vl_sh   = {vl[24:0], b[6:0]};
    bl_dec  = bl - 32'd1;
    do_mul  = 1'b0;
    do_note = 1'b0;
    note_on = 1'b0;
    data1   = 1'b0;
    note_b  = fd;
    vel_b   = b;
    kind    = '0;

    state_nxt = state_r;
    ph_nxt = ph_r; vl_nxt = vl_r; rs_nxt = rs_r; cs_nxt = cs_r; fd_nxt = fd_r;
    mk_nxt = mk_r; bl_nxt = bl_r; tg_nxt = tg_r; tempo_nxt = tempo_r;
    time_nxt = time_r; done_nxt = done_r; cnt_nxt = cnt_r; last_nxt = last_r;
    prod_nxt = prod_r; emit_nxt = emit_r;

    ctl     = '0;
    ch_cnt  = cnt_r;
    key     = '0;
    new_ent = '0;

    ld_out  = 1'b0;
    ld_last = 1'b0;
    src     = head;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ph_nxt = ph; vl_nxt = vl; rs_nxt = rs; cs_nxt = cs; fd_nxt = fd; mk_nxt = mk;
          bl_nxt = bl; tg_nxt = tg; time_nxt = tm; done_nxt = dn; cnt_nxt = cnt;
          tempo_nxt = tmp;
          if (!dn) begin
            case (ph)
              PH_DELTA: begin
                vl_nxt = vl_sh;
                if (!b[7]) begin
                  do_mul = !lst;
                  ph_nxt = PH_STATUS;
                end
              end
              PH_STATUS: begin
                if (!b[7]) begin
                  if (rs == 8'd0) begin
                    ph_nxt = PH_DELTA; vl_nxt = '0;
                  end else begin
                    cs_nxt = rs;
                    data1  = 1'b1;
                  end
                end else begin
                  cs_nxt = b;
                  rs_nxt = (b < ST_SYS) ? b : 8'd0;
                  vl_nxt = '0;
                  if (b == ST_META) begin
                    ph_nxt = PH_META_TYPE;
                  end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
                    ph_nxt = PH_SYSEX_LEN;
                  end else if (b < ST_SYS) begin
                    ph_nxt = PH_DATA1;
                  end else begin
                    ph_nxt = PH_DELTA;
                  end
                end
              end
              PH_DATA1: begin
                data1 = 1'b1;
              end
              PH_DATA2: begin
                kind = cs[7:4];
                do_note = (kind == KIND_OFF) || (kind == KIND_ON);
                note_on = (kind == KIND_ON) && (b != 8'd0);
                ph_nxt = PH_DELTA; vl_nxt = '0;
              end
              PH_META_TYPE: begin
                mk_nxt = b; vl_nxt = '0; ph_nxt = PH_META_LEN;
              end
              PH_META_LEN: begin
                vl_nxt = vl_sh;
                if (!b[7]) begin
                  bl_nxt = vl_sh;
                  tg_nxt = '0;
                  if (mk == META_TEMPO && vl_sh != 32'd3) begin
                    mk_nxt = '0;
                  end
                  if (mk == META_EOT) begin
                    done_nxt = 1'b1;
                  end else if (vl_sh == 32'd0) begin
                    ph_nxt = PH_DELTA; vl_nxt = '0;
                  end else begin
                    ph_nxt = PH_META_DATA;
                  end
                end
              end
              PH_META_DATA: begin
                tg_nxt = {tg[15:0], b};
                bl_nxt = bl_dec;
                if (bl_dec == 32'd0) begin
                  if (mk == META_TEMPO) begin
                    tempo_nxt = {tg[15:0], b};
                  end
                  ph_nxt = PH_DELTA; vl_nxt = '0;
                end
              end
              PH_SYSEX_LEN: begin
                vl_nxt = vl_sh;
                if (!b[7]) begin
                  bl_nxt = vl_sh;
                  if (vl_sh == 32'd0) begin
                    ph_nxt = PH_DELTA; vl_nxt = '0;
                  end else begin
                    ph_nxt = PH_SKIP;
                  end
                end
              end
              PH_SKIP: begin
                bl_nxt = bl_dec;
                if (bl_dec == 32'd0) begin
                  ph_nxt = PH_DELTA; vl_nxt = '0;
                end
              end
              default: begin
                ph_nxt = PH_DELTA; vl_nxt = '0;
              end
            endcase
            if (data1) begin
              fd_nxt = b;
              if (cs_nxt[7:4] == KIND_PROG || cs_nxt[7:4] == KIND_PRESS) begin
                ph_nxt = PH_DELTA; vl_nxt = '0;
              end else begin
                ph_nxt = PH_DATA2;
              end
            end
          end

          // Pending table: insert a note-on or close the oldest match
          ch_cnt        = cnt;
          key.note      = note_b;
          key.chan      = cs[3:0];
          new_ent.note  = note_b;
          new_ent.chan  = cs[3:0];
          new_ent.start = tm;
          new_ent.vel   = vel_b;
          if (do_note && note_on) begin
            ctl.ins = (cnt < CNT_W'(PEND_DEPTH));
            if (cnt < CNT_W'(PEND_DEPTH)) begin
              cnt_nxt = cnt + CNT_W'(1);
            end
          end else if (do_note && found) begin
            ctl.rm   = 1'b1;
            cnt_nxt  = cnt - CNT_W'(1);
            emit_nxt = hit_ent;
          end

          prod_nxt = vl_sh * tmp;
          last_nxt = lst;

          // Track end: drop parser state now, keep time and count for the flush
          if (lst) begin
            ph_nxt = PH_DELTA; vl_nxt = '0; rs_nxt = '0; cs_nxt = '0; fd_nxt = '0;
            mk_nxt = '0; bl_nxt = '0; tg_nxt = '0; done_nxt = 1'b0;
          end

          if (do_note && !note_on && found) begin
            state_nxt = S_EMIT;
          end else if (lst) begin
            state_nxt = S_FLUSH;
          end else if (do_mul) begin
            state_nxt = S_ADD;
          end
        end
      end
      S_ADD: begin
        time_nxt  = sum[64] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          ld_out    = 1'b1;
          src       = emit_r;
          ld_last   = !last_r || (cnt_r == '0);
          state_nxt = last_r ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (cnt_r == '0) begin
          time_nxt  = '0;
          state_nxt = S_IDLE;
        end else if (out_free) begin
          ld_out    = 1'b1;
          src       = head;
          ld_last   = (cnt_r == CNT_W'(1));
          ctl.shift = 1'b1;
          cnt_nxt   = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Output register: load a note or drain on ready
    ov_nxt      = ov_r && !out_if.ready;
    o_start_nxt = o_start_r;
    o_len_nxt   = o_len_r;
    o_pitch_nxt = o_pitch_r;
    o_vel_nxt   = o_vel_r;
    o_last_nxt  = o_last_r;
    if (ld_out) begin
      ov_nxt      = 1'b1;
      o_start_nxt = src.start;
      o_len_nxt   = (time_r >= src.start) ? (time_r - src.start) : '0;
      o_pitch_nxt = src.note;
      o_vel_nxt   = src.vel;
      o_last_nxt  = ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_DELTA;
      vl_r    <= '0;
      rs_r    <= '0;
      cs_r    <= '0;
      fd_r    <= '0;
      mk_r    <= '0;
      bl_r    <= '0;
      tg_r    <= '0;
      tempo_r <= TEMPO_RST;
      dflt_r  <= TEMPO_RST;
      time_r  <= '0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      vl_r    <= vl_nxt;
      rs_r    <= rs_nxt;
      cs_r    <= cs_nxt;
      fd_r    <= fd_nxt;
      mk_r    <= mk_nxt;
      bl_r    <= bl_nxt;
      tg_r    <= tg_nxt;
      tempo_r <= tempo_nxt;
      time_r  <= time_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr_en) begin
        dflt_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    emit_r    <= emit_nxt;
    o_start_r <= o_start_nxt;
    o_len_r   <= o_len_nxt;
    o_pitch_r <= o_pitch_nxt;
    o_vel_r   <= o_vel_nxt;
    o_last_r  <= o_last_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PEND_DEPTH))
    else $error("pending count beyond table depth");

  a_add_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |=> state_r == S_IDLE)
    else $error("time add did not return to idle");

  a_flush_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && cnt_r == '0) |=> (time_r == '0 && state_r == S_IDLE))
    else $error("flush end did not clear time");

  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT || state_r == S_FLUSH) |-> !in_if.ready)
    else $error("input taken while notes are emitted");
`endif

endmodule
`default_nettype wire

### src/mtne_cell.sv
// One pending-note cell: holds an entry, matches a key, takes its neighbor.
`timescale 1ns / 1ps
`default_nettype none
module mtne_cell (
  input  wire                      clk,
  input  wire mtne_pkg::cell_ctl_t ctl,
  input  wire                      active,
  input  wire                      ins_sel,
  input  wire mtne_pkg::pend_t     key,
  input  wire mtne_pkg::pend_t     new_ent,
  input  wire mtne_pkg::pend_t     nbr_ent,
  input  wire                      found_in,
  output mtne_pkg::pend_t          ent,
  output logic                     found_out,
  output logic                     hit
);
  import mtne_pkg::*;

  pend_t ent_r;
  logic  match;

  assign match     = active && (ent_r.note == key.note) && (ent_r.chan == key.chan);
  assign found_out = found_in | match;
  assign hit       = match & ~found_in;
  assign ent       = ent_r;

  always_ff @(posedge clk) begin
    if (ctl.shift || (ctl.rm && found_out)) begin
      ent_r <= nbr_ent;
    end else if (ctl.ins && ins_sel) begin
      ent_r <= new_ent;
    end
  end
endmodule
`default_nettype wire

### src/mtne_chain.sv
// Row of pending-note cells with oldest-match search and head readout.
`timescale 1ns / 1ps
`default_nettype none
module mtne_chain (
  input  wire                           clk,
  input  wire mtne_pkg::cell_ctl_t      ctl,
  input  wire [mtne_pkg::CNT_W-1:0]     cnt,
  input  wire mtne_pkg::pend_t          key,
  input  wire mtne_pkg::pend_t          new_ent,
  output logic                          found,
  output mtne_pkg::pend_t               hit_ent,
  output mtne_pkg::pend_t               head
);
  import mtne_pkg::*;

  pend_t ents [PEND_DEPTH];
  logic  fnd  [PEND_DEPTH+1];
  logic  hits [PEND_DEPTH];

  assign fnd[0] = 1'b0;

  for (genvar i = 0; i < PEND_DEPTH; i++) begin : g_cell
    pend_t nbr;
    if (i == PEND_DEPTH - 1) begin : g_end
      assign nbr = ents[i];
    end else begin : g_mid
      assign nbr = ents[i+1];
    end
    mtne_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .active   (cnt > CNT_W'(i)),
      .ins_sel  (cnt == CNT_W'(i)),
      .key      (key),
      .new_ent  (new_ent),
      .nbr_ent  (nbr),
      .found_in (fnd[i]),
      .ent      (ents[i]),
      .found_out(fnd[i+1]),
      .hit      (hits[i])
    );
  end

  assign found = fnd[PEND_DEPTH];
  assign head  = ents[0];

  always_comb begin
    hit_ent = '0;
    for (int i = 0; i < PEND_DEPTH; i++) begin
      if (hits[i]) begin
        hit_ent = hit_ent | ents[i];
      end
    end
  end
endmodule
`default_nettype wire
